>>> rtl/battery_voltage_window_filter_unit_assert.svh
// ----------------------------------------------------------------------------
// Battery voltage window filter assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_WINDOW_FILTER_UNIT_ASSERT_SVH
`define BATTERY_VOLTAGE_WINDOW_FILTER_UNIT_ASSERT_SVH

`ifndef SYNTH
// Property that must hold in the same cycle as its condition.
`define BVWF_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Property that must hold in the cycle after its condition.
`define BVWF_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define BVWF_ASSERT_NOW(label, cond, prop, msg)
`define BVWF_ASSERT_NEXT(label, cond, prop, msg)
`endif

`endif

>>> rtl/bvwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage window filter package
// Widths, register indexes and reset values shared by the filter's files.
// ----------------------------------------------------------------------------
package bvwf_pkg;

    // Window geometry.
    localparam int WINDOW_DEPTH = 40;
    localparam int SAMPLE_W     = 10;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
    localparam int ADDR_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = $clog2(WINDOW_DEPTH * SAMPLE_MAX + 1);

    // Trimmed average: ((sum - min) * 10 + 5) / (depth - 1) / 10.
    localparam int AVG_SCALE    = 10;
    localparam int AVG_ROUND    = 5;
    localparam int FULL_DIVISOR = (WINDOW_DEPTH - 1) * AVG_SCALE;
    localparam int NUM_W        = $clog2(WINDOW_DEPTH * SAMPLE_MAX * AVG_SCALE + AVG_ROUND + 1);
    localparam int DEN_W        = $clog2(FULL_DIVISOR + 1);
    localparam int DIV_CNT_W    = $clog2(NUM_W);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WINDOW_DEPTH - 1);

    // Hysteresis counters.
    localparam int LOW_CNT_W  = 16;
    localparam int HIGH_CNT_W = 8;

    // Configuration registers.
    localparam int THR_W        = 10;
    localparam int HOLD_W       = 8;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_COUNT    = CFG_INDEX_W'(1);

    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(330);
    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(20);

endpackage

>>> rtl/bvwf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module bvwf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/battery_voltage_window_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage window filter
// Keeps a ring of recent samples and reports the window maximum, or the window
// average (trimmed once the ring is full) once the battery has read low for long enough.
// ----------------------------------------------------------------------------
// Usage:
// - The input channel (in_valid, in_ready, sample) takes one sample word.
//   The block works on one word at a time; in_ready is high only while idle.
// - The output channel (out_valid, out_ready, level, using_average) gives
//   exactly one result word for every sample word.
// - A word is accepted, and written to the ring, in an idle cycle. Its result
//   is loaded after the states ST_SCAN (the ring is read through the RAM read
//   port), ST_SETUP, ST_DIV (the bit-serial divider) and ST_DECIDE. The block
//   takes the next word only once it is back in idle. The scan and the serial
//   divide set how often it can take a word.
// - The result sits in an output register, so a new sample is accepted while
//   the previous result waits; if the receiver still stalls when the next
//   result is ready, the block holds in its decision cycle.
// - The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   is always ready; index 0 is low_threshold, 1 is hold_count, others are
//   ignored. Write it only while the block is idle.
// - Reset empties the ring at once through per-entry valid flags, clears the
//   counters and loads threshold 330 and hold count 20.
// ----------------------------------------------------------------------------
`include "battery_voltage_window_filter_unit_assert.svh"

module battery_voltage_window_filter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bvwf_pkg::SAMPLE_W-1:0]       sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bvwf_pkg::SAMPLE_W-1:0]       level,
    output logic                                using_average,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bvwf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bvwf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import bvwf_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;

    logic [2:0]              state_reg, state_next;

    // Configuration registers.
    logic [THR_W-1:0]        thr_reg;
    logic [HOLD_W-1:0]       hold_reg;

    // Ring bookkeeping.
    logic [ADDR_W-1:0]       wr_idx_reg, wr_idx_next;
    logic [WINDOW_DEPTH-1:0] valid_reg;

    // Scan pipeline.
    logic [ADDR_W-1:0]       rd_addr_reg, rd_addr_next;
    logic                    issue_reg, issue_next;
    logic                    data_vld_reg, data_vld_next;
    logic [ADDR_W-1:0]       data_addr_reg, data_addr_next;
    logic                    data_bit_reg, data_bit_next;
    logic [SAMPLE_W-1:0]     ram_rd_data;
    logic [SAMPLE_W-1:0]     entry;

    // Scan accumulators.
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [SAMPLE_W-1:0]     hi_reg, hi_next;
    logic [SAMPLE_W-1:0]     lo_reg, lo_next;
    logic                    last_nz_reg, last_nz_next;

    // Divider.
    logic [NUM_W-1:0]        num_reg, num_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [DEN_W:0]          trial;
    logic                    trial_ge;
    logic [SUM_W-1:0]        trim_diff;

    // Hysteresis.
    logic [LOW_CNT_W-1:0]    low_cnt_reg, low_cnt_next;
    logic [HIGH_CNT_W-1:0]   high_cnt_reg, high_cnt_next;
    logic [LOW_CNT_W-1:0]    low_inc;
    logic [HIGH_CNT_W-1:0]   high_inc;
    logic [SAMPLE_W-1:0]     avg;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]     level_reg, level_next;
    logic                    use_avg_reg, use_avg_next;

    logic                    in_fire;
    logic                    out_free;

    assign in_ready      = (state_reg == ST_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign level         = level_reg;
    assign using_average = use_avg_reg;
    assign out_free      = !out_valid_reg || out_ready;

    // Sample ring storage.
    bvwf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (wr_idx_reg),
        .wr_data (sample),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    // An entry never written since reset reads as zero.
    assign entry = data_bit_reg ? ram_rd_data : '0;

    // Divider step: shift in the next dividend bit and try the subtraction.
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});
    assign avg      = num_reg[SAMPLE_W-1:0];

    // Trimmed sum for a full window.
    assign trim_diff = sum_reg - SUM_W'(lo_reg);

    // Saturating counter increments.
    assign low_inc  = (low_cnt_reg == '1) ? low_cnt_reg : low_cnt_reg + LOW_CNT_W'(1);
    assign high_inc = (high_cnt_reg == '1) ? high_cnt_reg : high_cnt_reg + HIGH_CNT_W'(1);

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        wr_idx_next    = wr_idx_reg;
        rd_addr_next   = rd_addr_reg;
        issue_next     = issue_reg;
        data_vld_next  = 1'b0;
        data_addr_next = rd_addr_reg;
        data_bit_next  = valid_reg[rd_addr_reg];
        sum_next       = sum_reg;
        count_next     = count_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        last_nz_next   = last_nz_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        low_cnt_next   = low_cnt_reg;
        high_cnt_next  = high_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        level_next     = level_reg;
        use_avg_next   = use_avg_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    wr_idx_next  = (wr_idx_reg == LAST_ADDR) ? '0 : wr_idx_reg + ADDR_W'(1);
                    rd_addr_next = '0;
                    issue_next   = 1'b1;
                    sum_next     = '0;
                    count_next   = '0;
                    hi_next      = '0;
                    lo_next      = SAMPLE_W'(SAMPLE_MAX);
                    last_nz_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one read a cycle; data comes back in the next cycle.
                data_vld_next = issue_reg;
                if (issue_reg)
                begin
                    if (rd_addr_reg == LAST_ADDR)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + ADDR_W'(1);
                    end
                end
                if (data_vld_reg)
                begin
                    if (entry != '0)
                    begin
                        sum_next   = sum_reg + SUM_W'(entry);
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if (entry > hi_reg)
                    begin
                        hi_next = entry;
                    end
                    if (entry < lo_reg)
                    begin
                        lo_next = entry;
                    end
                    if (data_addr_reg == LAST_ADDR)
                    begin
                        last_nz_next = (entry != '0);
                        state_next   = ST_SETUP;
                    end
                end
            end

            ST_SETUP:
            begin
                // Pick the dividend and divisor for the window average.
                rem_next     = '0;
                div_cnt_next = DIV_CNT_W'(NUM_W - 1);
                if (count_reg == '0)
                begin
                    num_next = '0;
                    den_next = DEN_W'(1);
                end
                else if (count_reg == COUNT_W'(WINDOW_DEPTH))
                begin
                    num_next = NUM_W'(trim_diff) * NUM_W'(AVG_SCALE) + NUM_W'(AVG_ROUND);
                    den_next = DEN_W'(FULL_DIVISOR);
                end
                else
                begin
                    num_next = NUM_W'(sum_reg);
                    den_next = DEN_W'(count_reg);
                end
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                // Restoring division, one quotient bit a cycle.
                num_next = {num_reg[NUM_W-2:0], trial_ge};
                if (trial_ge)
                begin
                    rem_next = DEN_W'(trial - {1'b0, den_reg});
                end
                else
                begin
                    rem_next = trial[DEN_W-1:0];
                end
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                end
            end

            ST_DECIDE:
            begin
                // Update the hysteresis counters and load the result word.
                if (out_free)
                begin
                    level_next   = hi_reg;
                    use_avg_next = 1'b0;
                    if (last_nz_reg)
                    begin
                        if (avg <= thr_reg)
                        begin
                            low_cnt_next  = low_inc;
                            high_cnt_next = '0;
                        end
                        else if (high_inc >= hold_reg)
                        begin
                            low_cnt_next  = '0;
                            high_cnt_next = '0;
                        end
                        else
                        begin
                            high_cnt_next = high_inc;
                        end
                        if (low_cnt_next >= LOW_CNT_W'(hold_reg))
                        begin
                            level_next   = avg;
                            use_avg_next = 1'b1;
                        end
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            valid_reg     <= '0;
            issue_reg     <= 1'b0;
            data_vld_reg  <= 1'b0;
            low_cnt_reg   <= '0;
            high_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= THR_RESET;
            hold_reg      <= HOLD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            issue_reg     <= issue_next;
            data_vld_reg  <= data_vld_next;
            low_cnt_reg   <= low_cnt_next;
            high_cnt_reg  <= high_cnt_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                valid_reg[wr_idx_reg] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LOW_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                    REG_HOLD_COUNT:    hold_reg <= cfg_data[HOLD_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= rd_addr_next;
        data_addr_reg <= data_addr_next;
        data_bit_reg  <= data_bit_next;
        sum_reg       <= sum_next;
        count_reg     <= count_next;
        hi_reg        <= hi_next;
        lo_reg        <= lo_next;
        last_nz_reg   <= last_nz_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        div_cnt_reg   <= div_cnt_next;
        level_reg     <= level_next;
        use_avg_reg   <= use_avg_next;
    end

    // Assertions.
    `BVWF_ASSERT_NOW(a_div_rem_bound, state_reg == ST_DIV, rem_reg < den_reg, "divider remainder not below divisor")
    `BVWF_ASSERT_NOW(a_count_bound, state_reg == ST_SETUP, count_reg <= COUNT_W'(WINDOW_DEPTH), "nonzero count exceeds window depth")
    `BVWF_ASSERT_NOW(a_avg_needs_low, out_valid_reg && use_avg_reg, low_cnt_reg >= LOW_CNT_W'(hold_reg), "average reported below hold count")
    `BVWF_ASSERT_NEXT(a_accept_starts_scan, in_fire, state_reg == ST_SCAN && issue_reg, "accepted word did not start a scan")

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery voltage window filter testbench
// Sends sample words through the filter under random idling on both channels
// and compares every result word with a local model of the ring, the trimmed
// average and the low/high hysteresis counters.
// ----------------------------------------------------------------------------
module tb;

    import bvwf_pkg::*;

    // Register indexes that map to nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = CFG_INDEX_W'(255);

    localparam int unsigned LOW_RUN_MAX  = 65535;
    localparam int unsigned HIGH_RUN_MAX = 255;
    localparam int          REPORT_LIMIT = 10;
    localparam int          LONG_STALL   = 400;
    localparam int          SETTLE       = 80;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic                using_average;
    } level_word_t;

    // DUT signals.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [SAMPLE_W-1:0]    sample = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [SAMPLE_W-1:0]    level;
    logic                   using_average;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Local copy of the filter state.
    logic [SAMPLE_W-1:0] ring_copy [WINDOW_DEPTH];
    int unsigned         ring_wr_idx = 0;
    int unsigned         low_run = 0;
    int unsigned         high_run = 0;
    logic [THR_W-1:0]    thr_copy = THR_RESET;
    logic [HOLD_W-1:0]   hold_copy = HOLD_RESET;

    level_word_t level_expected[$];

    // Idling and pressure controls.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_req = 0;
    int stall_left = 0;

    // Battery trace generator state.
    int trace_mv = 400;
    int dropout_left = 0;

    // Run statistics.
    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int average_words = 0;
    int reg_writes = 0;

    battery_voltage_window_filter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .level         (level),
        .using_average (using_average),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Updates the ring copy with one sample and queues the expected result word.
    task automatic filter_predict(input logic [SAMPLE_W-1:0] s);
        int unsigned total;
        int unsigned nonzero;
        int unsigned peak;
        int unsigned floor_v;
        int unsigned avg;
        level_word_t w;
        total   = 0;
        nonzero = 0;
        peak    = 0;
        floor_v = SAMPLE_MAX;
        ring_copy[ring_wr_idx] = s;
        ring_wr_idx = (ring_wr_idx == WINDOW_DEPTH - 1) ? 0 : ring_wr_idx + 1;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (ring_copy[i] != 0)
            begin
                total += ring_copy[i];
                nonzero++;
            end
            if (ring_copy[i] > peak)
                peak = ring_copy[i];
            if (ring_copy[i] < floor_v)
                floor_v = ring_copy[i];
        end
        // Full ring drops the minimum and rounds; a partial ring is a plain mean.
        if (nonzero == 0)
            avg = 0;
        else if (nonzero == WINDOW_DEPTH)
            avg = ((total - floor_v) * AVG_SCALE + AVG_ROUND) / (WINDOW_DEPTH - 1) / AVG_SCALE;
        else
            avg = total / nonzero;
        w.level = SAMPLE_W'(peak);
        w.using_average = 1'b0;
        // Hysteresis only runs once the last ring slot holds a reading.
        if (ring_copy[WINDOW_DEPTH - 1] != 0)
        begin
            if (avg <= thr_copy)
            begin
                if (low_run < LOW_RUN_MAX)
                    low_run++;
                high_run = 0;
            end
            else
            begin
                if (high_run < HIGH_RUN_MAX)
                    high_run++;
                if (high_run >= hold_copy)
                begin
                    low_run  = 0;
                    high_run = 0;
                end
            end
            if (low_run >= hold_copy)
            begin
                w.level = SAMPLE_W'(avg);
                w.using_average = 1'b1;
            end
        end
        level_expected.push_back(w);
    endtask

    // Offers one sample word after a random gap and waits for its acceptance.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        filter_predict(s);
        words_sent++;
    endtask

    // Stops offering samples and waits until every result word has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (level_expected.size() != 0)
            @(posedge clk);
    endtask

    // Writes one configuration register.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_LOW_THRESHOLD: thr_copy = data[THR_W-1:0];
            REG_HOLD_COUNT:    hold_copy = data[HOLD_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_filter(input int thr, input int hold);
        wait_for_results();
        write_register(REG_LOW_THRESHOLD, CFG_DATA_W'(thr));
        write_register(REG_HOLD_COUNT, CFG_DATA_W'(hold));
    endtask

    // Sends a battery trace that settles toward a target voltage. A rough trace
    // also carries dropouts, single zero readings and wild values.
    task automatic run_trace(input int n, input int target, input bit rough);
        int pick;
        int v;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            if (dropout_left != 0)
            begin
                dropout_left--;
                v = 0;
            end
            else if (rough && pick < 2)
            begin
                dropout_left = $urandom_range(1, WINDOW_DEPTH + 5);
                v = 0;
            end
            else if (rough && pick < 4)
                v = 0;
            else if (rough && pick < 8)
                v = $urandom_range(SAMPLE_MAX);
            else
            begin
                trace_mv = trace_mv + (target - trace_mv) / 8 + int'($urandom_range(8)) - 4;
                v = trace_mv + int'($urandom_range(10)) - 5;
                if (v < 1)
                    v = 1;
                if (v > SAMPLE_MAX)
                    v = SAMPLE_MAX;
            end
            send_sample(SAMPLE_W'(v));
        end
    endtask

    // Empty ring, zero samples and the extreme sample values.
    task automatic test_empty_and_extremes();
        send_sample('0);
        send_sample('0);
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample(SAMPLE_W'(1));
        send_sample(SAMPLE_W'(10'h155));
        send_sample(SAMPLE_W'(10'h2AA));
        send_sample('0);
        send_sample(SAMPLE_W'(512));
        send_sample(SAMPLE_W'(SAMPLE_MAX));
        send_sample('0);
        send_sample(SAMPLE_W'(1));
        send_sample(SAMPLE_W'(SAMPLE_MAX - 1));
        send_sample(SAMPLE_W'(330));
        send_sample(SAMPLE_W'(331));
        send_sample(SAMPLE_W'(329));
        send_sample('0);
    endtask

    // Unmapped indexes are ignored and the hold count keeps only its low bits.
    task automatic test_register_map();
        wait_for_results();
        write_register(REG_UNMAPPED_LO, CFG_DATA_W'(SAMPLE_MAX));
        write_register(REG_UNMAPPED_HI, '0);
        write_register(REG_HOLD_COUNT, CFG_DATA_W'(10'h3FF));
        write_register(REG_LOW_THRESHOLD, CFG_DATA_W'(SAMPLE_MAX));
        write_register(REG_HOLD_COUNT, CFG_DATA_W'(10'h301));
        run_trace(8, 500, 1'b1);
    endtask

    // Traces that cross the threshold in both directions.
    task automatic test_hysteresis(input bit from_reset_values);
        int thr;
        int hold;
        for (int seg = 0; seg < 2; seg++)
        begin
            if (seg == 0 && from_reset_values)
            begin
                thr  = THR_RESET;
                hold = HOLD_RESET;
            end
            else
            begin
                thr  = $urandom_range(80, 940);
                hold = $urandom_range(1, 30);
            end
            set_filter(thr, hold);
            run_trace(50, thr - 50, 1'b1);
            run_trace(50, thr + 50, 1'b1);
        end
    endtask

    // Highest threshold with the shortest hold: every full ring reads low.
    task automatic test_always_low();
        set_filter(SAMPLE_MAX, 1);
        run_trace(80, $urandom_range(1, SAMPLE_MAX), 1'b1);
    endtask

    // Zero threshold with the longest hold: almost nothing reads low.
    task automatic test_never_low();
        set_filter(0, 255);
        run_trace(60, $urandom_range(1, SAMPLE_MAX), 1'b1);
    endtask

    // Hold count of zero: every compare against it passes.
    task automatic test_zero_hold();
        int thr;
        thr = $urandom_range(100, 900);
        set_filter(thr, 0);
        run_trace(30, thr - 40, 1'b1);
        run_trace(30, thr + 40, 1'b1);
    endtask

    // A long clean low stretch reaches the longest hold, then a long high
    // stretch runs the high counter to the same limit and clears both.
    task automatic test_sustained_hold();
        set_filter(600, 255);
        run_trace(300, 300, 1'b0);
        run_trace(300, 900, 1'b0);
    endtask

    // The receiver stops for a long stretch while samples keep coming.
    task automatic test_backpressure();
        stall_req = LONG_STALL;
        run_trace(10, 500, 1'b0);
    endtask

    // Receiver: random ready, long hold-offs on request, and result checking.
    always @(posedge clk)
    begin : result_check
        level_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                words_checked++;
                if (level_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result word with none expected: level=%0d avg=%0b",
                                 $realtime, level, using_average);
                end
                else
                begin
                    want = level_expected.pop_front();
                    if (want.using_average)
                        average_words++;
                    if (level !== want.level || using_average !== want.using_average)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected level=%0d avg=%0b, got level=%0d avg=%0b",
                                     $realtime, want.level, want.using_average,
                                     level, using_average);
                    end
                end
            end
            if (stall_req != 0)
            begin
                stall_left = stall_req;
                stall_req  = 0;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Main sequence.
    initial
    begin
        int mode;
        for (int i = 0; i < WINDOW_DEPTH; i++)
            ring_copy[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_extremes();
        test_register_map();

        // Receiver idles more, then the sender, then neither.
        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 37; recv_idle_pct = 52; end
                1: begin send_idle_pct = 52; recv_idle_pct = 37; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            test_hysteresis(mode == 0);
            test_always_low();
            test_never_low();
            test_zero_hold();
        end
        test_sustained_hold();
        test_backpressure();

        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        $display("Run covered %0d sample words and %0d result words, %0d of them averages,",
                 words_sent, words_checked, average_words);
        $display("with %0d register writes and %0d mismatches.", reg_writes, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #3_000_000;
        $display("Timeout with %0d result words still outstanding.", level_expected.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
